// File: sv/ilir_pkg.sv
// shared types, codes and sizing helpers for the indexed list insert/remove unit
// no dependencies; used by every module of the block
package ilir_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int POS_W        = 9;
    localparam int VAL_W        = 32;
    localparam int FUNC_W       = 2;
    localparam int ST_W         = 2;
    localparam int CNT_OUT_W    = 9;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             insert_en;
        logic             remove_en;
        logic             write_en;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

    // number of 4-way levels needed to reduce n leaves to one
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = 4;
        while (span < n) begin
            span = span * 4;
            lv   = lv + 1;
        end
        return lv;
    endfunction

endpackage

// File: sv/ilir_cell.sv
// one list entry cell: holds a value and takes from its neighbors on shifts
// depends on ilir_pkg (cell_ctrl_t)
module ilir_cell #(
    parameter int IW  = 9,
    parameter int IDX = 0
) (
    input  logic                        aclk,
    input  ilir_pkg::cell_ctrl_t        ctrl,
    input  logic [IW-1:0]               pos,
    input  logic [ilir_pkg::VAL_W-1:0]  left_data,
    input  logic [ilir_pkg::VAL_W-1:0]  right_data,
    output logic [ilir_pkg::VAL_W-1:0]  data,
    output logic                        hit
);

    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    logic [ilir_pkg::VAL_W-1:0] data_reg;
    logic [ilir_pkg::VAL_W-1:0] data_next;

    // shift up above the insert point, down from the remove point; insert and write load the value at the point
    always_comb begin
        data_next = data_reg;
        if (ctrl.insert_en) begin
            if (MY_POS > pos) begin
                data_next = left_data;
            end else if (MY_POS == pos) begin
                data_next = ctrl.value;
            end
        end else if (ctrl.remove_en) begin
            if (MY_POS >= pos) begin
                data_next = right_data;
            end
        end else if (ctrl.write_en && (MY_POS == pos)) begin
            data_next = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (MY_POS == pos);

endmodule

// File: sv/ilir_read_tree.sv
// registered 4-way or-reduction that picks the one selected cell value
// depends on ilir_pkg (widths, tree_levels)
module ilir_read_tree #(
    parameter int N = ilir_pkg::CAPACITY_DEF
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [ilir_pkg::VAL_W-1:0]  leaf [N],
    output logic [ilir_pkg::VAL_W-1:0]  root
);

    localparam int LEVELS = ilir_pkg::tree_levels(N);
    localparam int N4     = 4 ** LEVELS;
    localparam int NI     = (N4 - 1) / 3;

    logic [ilir_pkg::VAL_W-1:0] leaf_pad [N4];
    logic [ilir_pkg::VAL_W-1:0] node_reg [NI];

    // pad the leaf row up to a full power of four
    for (genvar i = 0; i < N4; i++) begin : g_pad
        if (i < N) begin : g_real
            assign leaf_pad[i] = leaf[i];
        end else begin : g_zero
            assign leaf_pad[i] = '0;
        end
    end

    // heap-ordered nodes: children of node k are 4k+1 .. 4k+4
    for (genvar k = 0; k < NI; k++) begin : g_node
        if (4 * k + 1 >= NI) begin : g_bottom
            // bottom level samples the cells only when a request is taken
            always_ff @(posedge aclk) begin
                if (load) begin
                    node_reg[k] <= leaf_pad[4*k+1-NI] | leaf_pad[4*k+2-NI]
                                 | leaf_pad[4*k+3-NI] | leaf_pad[4*k+4-NI];
                end
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                node_reg[k] <= node_reg[4*k+1] | node_reg[4*k+2]
                             | node_reg[4*k+3] | node_reg[4*k+4];
            end
        end
    end

    assign root = node_reg[0];

endmodule

// File: sv/indexed_list_insert_remove_unit.sv
// Indexed list insert/remove unit: ordered list of signed 32-bit values.
// Input channel s_*: one request (func, position, value_in) per transfer.
// Output channel m_*: one result (value_out, status, element_count) per request.
// The list lives in a row of CAPACITY cells; insert and remove shift the
// entries from the position upward by one place in the cycle the request is
// taken. The value read or removed is collected from the cells through a
// registered 4-way or-tree of L = ceil(log4(CAPACITY)) levels (L = 4 at 256
// entries) into the output register. A new request is taken only once the
// last result has left the tree root for the output register.
// The output register decouples the sides: a new request is taken while a
// finished result still waits. If the receiver stalls longer, the next result
// waits at the tree root and s_ready stays low until it moves on.
// Reset (aresetn low, synchronous) empties the list and drops any result in
// flight; the cell contents are not cleared and are never read before they
// are written, since only positions below the count are ever read.
// Depends on ilir_pkg, ilir_cell and ilir_read_tree.
module indexed_list_insert_remove_unit #(
    parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ilir_pkg::FUNC_W-1:0]          s_func,
    input  logic [ilir_pkg::POS_W-1:0]           s_position,
    input  logic signed [ilir_pkg::VAL_W-1:0]    s_value_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ilir_pkg::VAL_W-1:0]    m_value_out,
    output logic [ilir_pkg::ST_W-1:0]            m_status,
    output logic [ilir_pkg::CNT_OUT_W-1:0]       m_element_count
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int WW     = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
    localparam int LEVELS = ilir_pkg::tree_levels(CAPACITY);
    localparam int LAT    = LEVELS - 1;
    localparam int LW     = (LAT > 0) ? $clog2(LAT + 1) : 1;
    localparam logic [WW-1:0] CAP_X = WW'(CAPACITY);

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           busy_reg;
    logic           busy_next;
    logic [LW-1:0]  lat_reg;
    logic [LW-1:0]  lat_next;

    logic [ilir_pkg::ST_W-1:0]      pend_status_reg;
    logic [ilir_pkg::CNT_OUT_W-1:0] pend_count_reg;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [ilir_pkg::VAL_W-1:0]     m_value_reg;
    logic [ilir_pkg::ST_W-1:0]      m_status_reg;
    logic [ilir_pkg::CNT_OUT_W-1:0] m_count_reg;

    logic                           accept;
    logic                           done;
    logic [WW-1:0]                  pos_x;
    logic [WW-1:0]                  cnt_x;
    logic [WW-1:0]                  cnt_next_x;
    logic [ilir_pkg::ST_W-1:0]      status;
    logic                           rd_sel;
    ilir_pkg::cell_ctrl_t           ctrl;

    logic [ilir_pkg::VAL_W-1:0]     cell_data [CAPACITY];
    logic                           cell_hit  [CAPACITY];
    logic [ilir_pkg::VAL_W-1:0]     leaf      [CAPACITY];
    logic [ilir_pkg::VAL_W-1:0]     root;

    assign s_ready = ~busy_reg;
    assign accept  = s_valid & s_ready;
    assign pos_x   = WW'(s_position);
    assign cnt_x   = WW'(count_reg);

    // range and capacity checks
    always_comb begin
        status = ilir_pkg::ST_OK;
        if (s_func == ilir_pkg::FUNC_INSERT) begin
            if (pos_x > cnt_x) begin
                status = ilir_pkg::ST_RANGE;
            end else if (cnt_x >= CAP_X) begin
                status = ilir_pkg::ST_FULL;
            end
        end else if (pos_x >= cnt_x) begin
            status = ilir_pkg::ST_RANGE;
        end
    end

    // cell broadcast and count update
    always_comb begin
        ctrl.insert_en = accept && (status == ilir_pkg::ST_OK)
                         && (s_func == ilir_pkg::FUNC_INSERT);
        ctrl.remove_en = accept && (status == ilir_pkg::ST_OK)
                         && (s_func == ilir_pkg::FUNC_REMOVE);
        ctrl.write_en  = accept && (status == ilir_pkg::ST_OK)
                         && (s_func == ilir_pkg::FUNC_WRITE);
        ctrl.value     = s_value_in;
        rd_sel         = (status == ilir_pkg::ST_OK)
                         && ((s_func == ilir_pkg::FUNC_REMOVE)
                             || (s_func == ilir_pkg::FUNC_READ));
        count_next = count_reg;
        if (ctrl.insert_en) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.remove_en) begin
            count_next = count_reg - CW'(1);
        end
        cnt_next_x = WW'(count_next);
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ilir_pkg::VAL_W-1:0] left_d;
        logic [ilir_pkg::VAL_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end
        ilir_cell #(
            .IW  (WW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos_x),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit        (cell_hit[i])
        );
        assign leaf[i] = (rd_sel && cell_hit[i]) ? cell_data[i] : '0;
    end

    // read-out tree, sampled before the cells shift
    ilir_read_tree #(
        .N (CAPACITY)
    ) u_tree (
        .aclk (aclk),
        .load (accept),
        .leaf (leaf),
        .root (root)
    );

    // in-flight tracking: wait for the tree, then hand over to the output
    assign done = busy_reg && (lat_reg == '0) && (~m_valid_reg || m_ready);

    always_comb begin
        busy_next = busy_reg;
        lat_next  = lat_reg;
        if (accept) begin
            busy_next = 1'b1;
            lat_next  = LW'(LAT);
        end else if (done) begin
            busy_next = 1'b0;
        end else if (busy_reg && (lat_reg != '0)) begin
            lat_next = lat_reg - LW'(1);
        end
        m_valid_next = m_valid_reg;
        if (done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            lat_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            lat_reg     <= lat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg <= status;
            pend_count_reg  <= cnt_next_x[ilir_pkg::CNT_OUT_W-1:0];
        end
        if (done) begin
            m_value_reg  <= root;
            m_status_reg <= pend_status_reg;
            m_count_reg  <= pend_count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_value_out     = m_value_reg;
    assign m_status        = m_status_reg;
    assign m_element_count = m_count_reg;

endmodule

// File: sv/ilir_checker.sv
// port-level checks for the indexed list insert/remove unit, bound to the top
// depends on ilir_pkg and indexed_list_insert_remove_unit
module ilir_checker #(
    parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [ilir_pkg::FUNC_W-1:0]          s_func,
    input logic [ilir_pkg::POS_W-1:0]           s_position,
    input logic signed [ilir_pkg::VAL_W-1:0]    s_value_in,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [ilir_pkg::VAL_W-1:0]    m_value_out,
    input logic [ilir_pkg::ST_W-1:0]            m_status,
    input logic [ilir_pkg::CNT_OUT_W-1:0]       m_element_count
);

    localparam logic [ilir_pkg::CNT_OUT_W-1:0] CAP_OUT =
        ilir_pkg::CNT_OUT_W'(CAPACITY);

    // waiting request holds its payload
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_func) && $stable(s_position)
                                && $stable(s_value_in))
        else $error("request changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out)
                                && $stable(m_status) && $stable(m_element_count))
        else $error("result changed while stalled");

    // only defined status codes
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ilir_pkg::ST_OK) || (m_status == ilir_pkg::ST_RANGE)
                    || (m_status == ilir_pkg::ST_FULL))
        else $error("undefined status code");

    // rejected requests return zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ilir_pkg::ST_OK) |-> m_value_out == '0)
        else $error("rejected request returned a value");

    // full status only when the list is at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ilir_pkg::ST_FULL) |-> m_element_count == CAP_OUT)
        else $error("full status with list below capacity");

endmodule

bind indexed_list_insert_remove_unit ilir_checker #(
    .CAPACITY (CAPACITY)
) u_ilir_checker (.*);
